// File: sv/pllb_pkg.sv
// pllb_pkg: shared types and codes for the pooled linked-list allocator
// used by pllb_ctrl, pllb_dp and pool_linked_list_bitmap_alloc
// no dependencies
package pllb_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND   = 2'd0,
        CMD_RM_HEAD  = 2'd1,
        CMD_RM_AFTER = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch item, issue first memory read
        logic exec;     // first data back: execute the command
        logic fin;      // second data back: finish remove-after
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic is_rm_after;
        logic pred_ok;
    } stat_t;

endpackage

// File: sv/pllb_ctrl.sv
// pllb_ctrl: sequencing state machine of the list allocator
// depends on pllb_pkg
module pllb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pllb_pkg::stat_t stat,
    output pllb_pkg::ctl_t  ctl,
    output logic            busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second;

    assign second = stat.is_rm_after && stat.pred_ok;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = second ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign ctl.accept = (state_reg == S_IDLE) && start;
    assign ctl.exec   = (state_reg == S_EXEC);
    assign ctl.fin    = (state_reg == S_FIN);

endmodule

// File: sv/pllb_dp.sv
// pllb_dp: pool memories, free bitmap, link valid bits, list pointers, result registers
// depends on pllb_pkg; sequenced by pllb_ctrl
module pllb_dp #(
    parameter int ENTRIES      = 32,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pllb_pkg::ctl_t  ctl,
    output pllb_pkg::stat_t stat,
    input  logic [1:0]      cmd,
    input  logic [4:0]      node_index,
    input  logic [31:0]     key_in,
    input  logic [31:0]     value_in,
    output logic            done,
    output logic [1:0]      status,
    output logic [4:0]      slot_index,
    output logic [31:0]     key_out,
    output logic [31:0]     value_out,
    output logic [4:0]      next_slot,
    output logic            has_next,
    output logic [4:0]      head_slot,
    output logic            list_empty,
    output logic [5:0]      entry_count
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int HW = HANDLE_WIDTH;

    // pool storage, no reset: only data of allocated slots is ever returned
    logic [HW-1:0] key_mem  [ENTRIES];
    logic [HW-1:0] val_mem  [ENTRIES];
    logic [SW-1:0] link_mem [ENTRIES];

    logic [HW-1:0] key_rd;
    logic [HW-1:0] val_rd;
    logic [SW-1:0] link_rd;

    logic [ENTRIES-1:0] free_map_reg, free_next;
    logic [ENTRIES-1:0] lvalid_reg, lvalid_next;
    logic [SW-1:0]      head_reg, head_next;
    logic [SW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SW-1:0]      victim_reg, victim_next;

    pllb_pkg::cmd_t cmd_reg;
    logic           pred_ok_reg;
    logic           read_ok_reg;
    logic [SW-1:0]  idx_reg;
    logic [HW-1:0]  key_reg;
    logic [HW-1:0]  val_reg;

    logic [6:0]    idx_w;
    logic [SW-1:0] idx_sw;
    logic          idx_in_range;
    logic          pred_ok_in;
    logic          read_ok_in;
    logic [63:0]   key_in_w;
    logic [63:0]   val_in_w;

    logic [SW-1:0] found;
    logic          pool_full;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          lk_we;
    logic [SW-1:0] lk_waddr;
    logic [SW-1:0] lk_wdata;
    logic          kv_we;

    logic          done_next;
    logic [1:0]    r_status;
    logic [SW-1:0] r_slot;
    logic [HW-1:0] r_key;
    logic [HW-1:0] r_val;
    logic [SW-1:0] r_next;
    logic          r_has;
    logic [6:0]    r_slot_w;
    logic [6:0]    r_next_w;
    logic [63:0]   r_key_w;
    logic [63:0]   r_val_w;

    logic          done_reg;
    logic [1:0]    status_reg;
    logic [4:0]    slot_reg;
    logic [31:0]   key_out_reg;
    logic [31:0]   val_out_reg;
    logic [4:0]    next_reg;
    logic          has_next_reg;

    logic [6:0]    head_w;
    logic [6:0]    count_w;

    // input decode at accept
    assign idx_w        = 7'(node_index);
    assign idx_sw       = idx_w[SW-1:0];
    assign idx_in_range = (idx_w < 7'(ENTRIES));
    assign read_ok_in   = idx_in_range && !free_map_reg[idx_sw];
    assign pred_ok_in   = read_ok_in && lvalid_reg[idx_sw];
    assign key_in_w     = 64'(key_in);
    assign val_in_w     = 64'(value_in);

    assign stat.is_rm_after = (cmd_reg == pllb_pkg::CMD_RM_AFTER);
    assign stat.pred_ok     = pred_ok_reg;

    // lowest free slot
    always_comb
    begin
        found = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (free_map_reg[i])
            begin
                found = SW'(i);
            end
        end
    end

    assign pool_full = (free_map_reg == '0) || (count_reg >= CW'(ENTRIES));

    always_comb
    begin
        free_next   = free_map_reg;
        lvalid_next = lvalid_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        victim_next = victim_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_sw;
        lk_we       = 1'b0;
        lk_waddr    = tail_reg;
        lk_wdata    = found;
        kv_we       = 1'b0;
        done_next   = 1'b0;
        r_status    = pllb_pkg::ST_OK;
        r_slot      = '0;
        r_key       = '0;
        r_val       = '0;
        r_next      = '0;
        r_has       = 1'b0;

        if (ctl.accept)
        begin
            rd_en   = 1'b1;
            rd_addr = (pllb_pkg::cmd_t'(cmd) == pllb_pkg::CMD_RM_HEAD) ? head_reg : idx_sw;
        end

        if (ctl.exec)
        begin
            unique case (cmd_reg)
                pllb_pkg::CMD_APPEND:
                begin
                    done_next = 1'b1;
                    if (pool_full)
                    begin
                        r_status = pllb_pkg::ST_FULL;
                    end
                    else
                    begin
                        kv_we              = 1'b1;
                        free_next[found]   = 1'b0;
                        lvalid_next[found] = 1'b0;
                        if (count_reg == '0)
                        begin
                            head_next = found;
                        end
                        else
                        begin
                            // link the old tail to the new slot
                            lk_we                 = 1'b1;
                            lvalid_next[tail_reg] = 1'b1;
                        end
                        tail_next  = found;
                        count_next = count_reg + 1'b1;
                        r_slot     = found;
                    end
                end
                pllb_pkg::CMD_RM_HEAD:
                begin
                    done_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        r_status = pllb_pkg::ST_ERR;
                    end
                    else
                    begin
                        r_slot = head_reg;
                        r_key  = key_rd;
                        r_val  = val_rd;
                        if (lvalid_reg[head_reg])
                        begin
                            head_next = link_rd;
                        end
                        else
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        lvalid_next[head_reg] = 1'b0;
                        free_next[head_reg]   = 1'b1;
                        count_next            = count_reg - 1'b1;
                    end
                end
                pllb_pkg::CMD_RM_AFTER:
                begin
                    if (pred_ok_reg)
                    begin
                        // fetch the victim named by the predecessor's link
                        rd_en       = 1'b1;
                        rd_addr     = link_rd;
                        victim_next = link_rd;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        r_status  = pllb_pkg::ST_ERR;
                    end
                end
                pllb_pkg::CMD_READ:
                begin
                    done_next = 1'b1;
                    if (read_ok_reg)
                    begin
                        r_slot = idx_reg;
                        r_key  = key_rd;
                        r_val  = val_rd;
                        r_has  = lvalid_reg[idx_reg];
                        r_next = lvalid_reg[idx_reg] ? link_rd : '0;
                    end
                    else
                    begin
                        r_status = pllb_pkg::ST_ERR;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end

        if (ctl.fin)
        begin
            done_next               = 1'b1;
            r_slot                  = victim_reg;
            r_key                   = key_rd;
            r_val                   = val_rd;
            lk_we                   = 1'b1;
            lk_waddr                = idx_reg;
            lk_wdata                = link_rd;
            lvalid_next[idx_reg]    = lvalid_reg[victim_reg];
            lvalid_next[victim_reg] = 1'b0;
            free_next[victim_reg]   = 1'b1;
            if (tail_reg == victim_reg)
            begin
                tail_next = idx_reg;
            end
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // pool memories, registered read
    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            key_mem[found] <= key_reg;
            val_mem[found] <= val_reg;
        end
        if (lk_we)
        begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        if (rd_en)
        begin
            key_rd  <= key_mem[rd_addr];
            val_rd  <= val_mem[rd_addr];
            link_rd <= link_mem[rd_addr];
        end
    end

    // item payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            idx_reg <= idx_sw;
            key_reg <= key_in_w[HW-1:0];
            val_reg <= val_in_w[HW-1:0];
        end
        victim_reg <= victim_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= pllb_pkg::CMD_APPEND;
            pred_ok_reg  <= 1'b0;
            read_ok_reg  <= 1'b0;
            free_map_reg <= '1;
            lvalid_reg   <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                cmd_reg     <= pllb_pkg::cmd_t'(cmd);
                pred_ok_reg <= pred_ok_in;
                read_ok_reg <= read_ok_in;
            end
            free_map_reg <= free_next;
            lvalid_reg   <= lvalid_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
        end
    end

    // result fields, cut or widened to port widths
    assign r_slot_w = 7'(r_slot);
    assign r_next_w = 7'(r_next);
    assign r_key_w  = 64'(r_key);
    assign r_val_w  = 64'(r_val);

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            status_reg   <= r_status;
            slot_reg     <= r_slot_w[4:0];
            key_out_reg  <= r_key_w[31:0];
            val_out_reg  <= r_val_w[31:0];
            next_reg     <= r_next_w[4:0];
            has_next_reg <= r_has;
        end
    end

    assign head_w  = 7'(head_reg);
    assign count_w = 7'(count_reg);

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign key_out     = key_out_reg;
    assign value_out   = val_out_reg;
    assign next_slot   = next_reg;
    assign has_next    = has_next_reg;
    assign head_slot   = (count_reg == '0) ? 5'd0 : head_w[4:0];
    assign list_empty  = (count_reg == '0);
    assign entry_count = count_w[5:0];

endmodule

// File: sv/pool_linked_list_bitmap_alloc.sv
// done follows acceptance through the execute state and the done register, and a
// remove-after with a valid predecessor also passes the finish state; items are taken only
// in idle; each step waits on registered pool reads (a second read fetches the victim)
// busy is high from the cycle after acceptance until done pulses; done is never held
// reset: asynchronous active low; every slot free, list empty, head and tail at slot zero
module pool_linked_list_bitmap_alloc #(
    parameter int ENTRIES      = 32,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // command side: item taken when start is high and busy is low
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [4:0]  node_index,
    input  logic [31:0] key_in,
    input  logic [31:0] value_in,
    // result side: fields valid for the single cycle in which done is high
    output logic        done,
    output logic [1:0]  status,
    output logic [4:0]  slot_index,
    output logic [31:0] key_out,
    output logic [31:0] value_out,
    output logic [4:0]  next_slot,
    output logic        has_next,
    output logic [4:0]  head_slot,
    output logic        list_empty,
    output logic [5:0]  entry_count
);

    // controller and datapath exchange only these two groups
    pllb_pkg::ctl_t  ctl;
    pllb_pkg::stat_t stat;

    // sequencer: idle, execute on first read data, finish on victim data
    pllb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // pool memories with free bitmap, link valid bits and list pointers
    pllb_dp #(
        .ENTRIES      (ENTRIES),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .node_index  (node_index),
        .key_in      (key_in),
        .value_in    (value_in),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index),
        .key_out     (key_out),
        .value_out   (value_out),
        .next_slot   (next_slot),
        .has_next    (has_next),
        .head_slot   (head_slot),
        .list_empty  (list_empty),
        .entry_count (entry_count)
    );

endmodule
